FILE: hw/rtl/max_pool_2d_forward_assert.svh
// ----------------------------------------------------------------------------
// max pool assertion macros
// shared concurrent assertion forms, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef MAX_POOL_2D_FORWARD_ASSERT_SVH
`define MAX_POOL_2D_FORWARD_ASSERT_SVH

// same-cycle implication
`define MP2D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MP2D_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mp2d_pkg.sv
// ----------------------------------------------------------------------------
// max pool package
// sample and index types, register codes, reset values, reciprocal table
// ----------------------------------------------------------------------------
package mp2d_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int IDX_BITS      = 10;
  localparam int KCFG_BITS     = 4;
  localparam int DIM_BITS      = 11;
  localparam int CFG_DATA_BITS = 11;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [IDX_BITS-1:0]           idx_t;

  typedef enum logic [1:0] {
    CFG_KERNEL_SIZE,
    CFG_STRIDE_STEP,
    CFG_PLANE_WIDTH,
    CFG_PLANE_HEIGHT
  } cfg_idx_t;

  localparam logic [KCFG_BITS-1:0] KERNEL_RST = 4'd2;
  localparam logic [KCFG_BITS-1:0] STRIDE_RST = 4'd2;
  localparam logic [DIM_BITS-1:0]  WIDTH_RST  = 11'd32;
  localparam logic [DIM_BITS-1:0]  HEIGHT_RST = 11'd32;

  // ceil(2^18 / s) for s = 1..16, exact quotient for x * s below 2^18
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_BITS  = 19;
  localparam logic [RECIP_BITS-1:0] RECIP [16] = '{
    19'd262144, 19'd131072, 19'd87382, 19'd65536,
    19'd52429,  19'd43691,  19'd37450, 19'd32768,
    19'd29128,  19'd26215,  19'd23832, 19'd21846,
    19'd20165,  19'd18725,  19'd17477, 19'd16384
  };

endpackage

FILE: hw/rtl/mp2d_in_if.sv
// ----------------------------------------------------------------------------
// max pool sample channel
// valid/ready stream of input samples
// ----------------------------------------------------------------------------
interface mp2d_in_if;
  logic              valid;
  logic              ready;
  mp2d_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

FILE: hw/rtl/mp2d_out_if.sv
// ----------------------------------------------------------------------------
// max pool result channel
// valid/ready stream of window maxima with position and end-of-plane flag
// ----------------------------------------------------------------------------
interface mp2d_out_if;
  logic              valid;
  logic              ready;
  mp2d_pkg::sample_t pooled_max;
  mp2d_pkg::idx_t    out_row;
  mp2d_pkg::idx_t    out_col;
  logic              plane_done;

  modport source (output valid, output pooled_max, output out_row, output out_col,
                  output plane_done, input ready);
  modport sink   (input valid, input pooled_max, input out_row, input out_col,
                  input plane_done, output ready);
endinterface

FILE: hw/rtl/mp2d_line_cell.sv
// ----------------------------------------------------------------------------
// max pool line cell
// one column store of running vertical maxima; cell j holds the maximum of
// the last j+1 rows per column and feeds its old value to cell j+1
// ----------------------------------------------------------------------------
module mp2d_line_cell #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  mp2d_pkg::sample_t nb_in,
  input  mp2d_pkg::sample_t x_in,
  output mp2d_pkg::sample_t rd_out,
  output mp2d_pkg::sample_t wr_out
);

  mp2d_pkg::sample_t mem [DEPTH];
  mp2d_pkg::sample_t rd_r;
  mp2d_pkg::sample_t upd;

  assign upd = (nb_in > x_in) ? nb_in : x_in;

  // bypass the write in flight when the next transfer hits the same column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= upd;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_r <= upd;
      end else begin
        rd_r <= mem[rd_addr];
      end
    end
  end

  assign rd_out = rd_r;
  assign wr_out = upd;

endmodule

FILE: hw/rtl/mp2d_win_cell.sv
// ----------------------------------------------------------------------------
// max pool window cell
// cell j holds the maximum of the last j+1 column maxima of the row
// ----------------------------------------------------------------------------
module mp2d_win_cell (
  input  logic              clk,
  input  logic              en,
  input  mp2d_pkg::sample_t nb_in,
  input  mp2d_pkg::sample_t x_in,
  output mp2d_pkg::sample_t run_out,
  output mp2d_pkg::sample_t nxt_out
);

  mp2d_pkg::sample_t run_r;
  mp2d_pkg::sample_t run_nxt;

  assign run_nxt = (nb_in > x_in) ? nb_in : x_in;

  always_ff @(posedge clk) begin
    if (en) begin
      run_r <= run_nxt;
    end
  end

  assign run_out = run_r;
  assign nxt_out = run_nxt;

endmodule

FILE: hw/rtl/max_pool_2d_forward.sv
// ----------------------------------------------------------------------------
// max pool 2d forward
// streaming KxK max pooling of raster-order Q8.8 planes with stride
// ----------------------------------------------------------------------------
// channel  | dir | payload                                   | handshake
// in_ch    | in  | sample                                    | valid/ready
// out_ch   | out | pooled_max, out_row, out_col, plane_done  | valid/ready
// cfg_*    | in  | cfg_index, cfg_data                       | cfg_we, no wait
//
// one sample per cycle unless stalled, via stage 1, stage 2 and output register
// the line cells read and rewrite one column per unstalled cycle, with bypass
// an output stall holds every stage and drops in_ch.ready
// synchronous reset clears counters and valids and loads config defaults;
// the line store and data registers are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
`include "max_pool_2d_forward_assert.svh"

module max_pool_2d_forward #(
  parameter int MAX_KERNEL = 8,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  mp2d_in_if.sink                               in_ch,
  mp2d_out_if.source                            out_ch,
  input  logic                                  cfg_we,
  input  mp2d_pkg::cfg_idx_t                    cfg_index,
  input  logic [mp2d_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int KW  = $clog2(MAX_KERNEL + 1);
  localparam int KI  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RPW = RW + mp2d_pkg::RECIP_BITS;
  localparam int CPW = CW + mp2d_pkg::RECIP_BITS;

  // configuration
  logic [mp2d_pkg::KCFG_BITS-1:0] kernel_size_r;
  logic [mp2d_pkg::KCFG_BITS-1:0] stride_step_r;
  logic [mp2d_pkg::DIM_BITS-1:0]  plane_width_r;
  logic [mp2d_pkg::DIM_BITS-1:0]  plane_height_r;

  logic [KW-1:0] k_eff;
  logic [KW-1:0] s_eff;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [KI-1:0] k_sel;
  logic [mp2d_pkg::RECIP_BITS-1:0] recip;

  // counters and handshake
  logic          adv;
  logic          acc;
  logic [CW-1:0] col_cnt_r;
  logic [RW-1:0] row_cnt_r;
  logic [CW-1:0] c_pre;
  logic [RW:0]   r_inc;
  logic [RW-1:0] r_pre;
  logic [CW:0]   c_n;
  logic [RW:0]   r_n;
  logic [CW-1:0] col_nxt;
  logic [RW-1:0] row_nxt;

  // stage 1
  logic              v1_r;
  mp2d_pkg::sample_t samp1_r;
  logic [RW-1:0]     r1_r;
  logic [CW-1:0]     c1_r;
  logic              ok1;
  logic              last1;
  logic [RW-1:0]     xr1;
  logic [CW-1:0]     xc1;
  mp2d_pkg::sample_t colmax1;

  // stage 2
  logic              v2_r;
  logic              ok2_r;
  logic              last2_r;
  logic [RW-1:0]     xr2_r;
  logic [CW-1:0]     xc2_r;
  logic [RPW-1:0]    pr2_r;
  logic [CPW-1:0]    pc2_r;
  mp2d_pkg::sample_t colmax2_r;
  logic [RW-1:0]     qr2;
  logic [CW-1:0]     qc2;
  logic              emit2;

  // output register
  logic              out_valid_r;
  mp2d_pkg::sample_t pooled_r;
  mp2d_pkg::idx_t    orow_r;
  mp2d_pkg::idx_t    ocol_r;
  logic              pdone_r;

  // cell chains
  mp2d_pkg::sample_t line_nb  [MAX_KERNEL];
  mp2d_pkg::sample_t line_rd  [MAX_KERNEL];
  mp2d_pkg::sample_t line_wr  [MAX_KERNEL];
  mp2d_pkg::sample_t win_nb   [MAX_KERNEL];
  mp2d_pkg::sample_t win_run  [MAX_KERNEL];
  mp2d_pkg::sample_t win_nxt  [MAX_KERNEL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_size_r  <= mp2d_pkg::KERNEL_RST;
      stride_step_r  <= mp2d_pkg::STRIDE_RST;
      plane_width_r  <= mp2d_pkg::WIDTH_RST;
      plane_height_r <= mp2d_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mp2d_pkg::CFG_KERNEL_SIZE:  kernel_size_r  <= cfg_data[mp2d_pkg::KCFG_BITS-1:0];
        mp2d_pkg::CFG_STRIDE_STEP:  stride_step_r  <= cfg_data[mp2d_pkg::KCFG_BITS-1:0];
        mp2d_pkg::CFG_PLANE_WIDTH:  plane_width_r  <= cfg_data;
        mp2d_pkg::CFG_PLANE_HEIGHT: plane_height_r <= cfg_data;
      endcase
    end
  end

  // zero acts as one, values above the maximum act as the maximum
  always_comb begin
    if (kernel_size_r == '0) begin
      k_eff = KW'(1);
    end else if (32'(kernel_size_r) > MAX_KERNEL) begin
      k_eff = KW'(MAX_KERNEL);
    end else begin
      k_eff = KW'(kernel_size_r);
    end
    if (stride_step_r == '0) begin
      s_eff = KW'(1);
    end else if (32'(stride_step_r) > MAX_KERNEL) begin
      s_eff = KW'(MAX_KERNEL);
    end else begin
      s_eff = KW'(stride_step_r);
    end
    if (plane_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(plane_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(plane_width_r);
    end
    if (plane_height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(plane_height_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(plane_height_r);
    end
  end

  assign k_sel = KI'(32'(k_eff) - 32'd1);
  assign recip = mp2d_pkg::RECIP[4'(32'(s_eff) - 32'd1)];

  assign adv          = !out_valid_r || out_ch.ready;
  assign acc          = in_ch.valid && adv;
  assign in_ch.ready  = adv;

  // position of this sample and of the next one
  always_comb begin
    if (32'(col_cnt_r) >= 32'(w_eff)) begin
      c_pre = '0;
      r_inc = {1'b0, row_cnt_r} + (RW+1)'(1);
    end else begin
      c_pre = col_cnt_r;
      r_inc = {1'b0, row_cnt_r};
    end
    r_pre = (32'(r_inc) >= 32'(h_eff)) ? '0 : RW'(r_inc);
    c_n   = {1'b0, c_pre} + (CW+1)'(1);
    r_n   = {1'b0, r_pre} + (RW+1)'(1);
    if (32'(c_n) >= 32'(w_eff)) begin
      col_nxt = '0;
      row_nxt = (32'(r_n) >= 32'(h_eff)) ? '0 : RW'(r_n);
    end else begin
      col_nxt = CW'(c_n);
      row_nxt = r_pre;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        col_cnt_r <= col_nxt;
        row_cnt_r <= row_nxt;
      end
      if (adv) begin
        v1_r        <= in_ch.valid;
        v2_r        <= v1_r;
        out_valid_r <= emit2;
      end
    end
  end

  // window origin offsets and fit checks
  assign ok1 = (32'(k_eff) <= 32'(w_eff)) && (32'(k_eff) <= 32'(h_eff)) &&
               ((32'(r1_r) + 32'd1) >= 32'(k_eff)) &&
               ((32'(c1_r) + 32'd1) >= 32'(k_eff));
  assign xr1 = RW'(32'(r1_r) + 32'd1 - 32'(k_eff));
  assign xc1 = CW'(32'(c1_r) + 32'd1 - 32'(k_eff));
  assign last1 = ((32'(r1_r) + 32'(s_eff)) >= 32'(h_eff)) &&
                 ((32'(c1_r) + 32'(s_eff)) >= 32'(w_eff));
  assign colmax1 = line_wr[k_sel];

  always_ff @(posedge clk) begin
    if (acc) begin
      samp1_r <= in_ch.sample;
      r1_r    <= r_pre;
      c1_r    <= c_pre;
    end
    if (adv) begin
      ok2_r     <= ok1;
      last2_r   <= last1;
      xr2_r     <= xr1;
      xc2_r     <= xc1;
      pr2_r     <= RPW'(xr1) * RPW'(recip);
      pc2_r     <= CPW'(xc1) * CPW'(recip);
      colmax2_r <= colmax1;
    end
  end

  assign qr2   = RW'(pr2_r >> mp2d_pkg::RECIP_SHIFT);
  assign qc2   = CW'(pc2_r >> mp2d_pkg::RECIP_SHIFT);
  assign emit2 = v2_r && ok2_r &&
                 ((RW+KW)'(qr2) * (RW+KW)'(s_eff) == (RW+KW)'(xr2_r)) &&
                 ((CW+KW)'(qc2) * (CW+KW)'(s_eff) == (CW+KW)'(xc2_r));

  always_ff @(posedge clk) begin
    if (adv && emit2) begin
      pooled_r <= win_nxt[k_sel];
      orow_r   <= mp2d_pkg::IDX_BITS'(qr2);
      ocol_r   <= mp2d_pkg::IDX_BITS'(qc2);
      pdone_r  <= last2_r;
    end
  end

  for (genvar j = 0; j < MAX_KERNEL; j++) begin : g_line
    if (j == 0) begin : g_head
      assign line_nb[j] = samp1_r;
    end else begin : g_body
      assign line_nb[j] = line_rd[j-1];
    end
    mp2d_line_cell #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
    ) u_cell (
      .clk     (clk),
      .rd_en   (acc),
      .rd_addr (c_pre),
      .wr_en   (adv && v1_r),
      .wr_addr (c1_r),
      .nb_in   (line_nb[j]),
      .x_in    (samp1_r),
      .rd_out  (line_rd[j]),
      .wr_out  (line_wr[j])
    );
  end

  for (genvar j = 0; j < MAX_KERNEL; j++) begin : g_win
    if (j == 0) begin : g_head
      assign win_nb[j] = colmax2_r;
    end else begin : g_body
      assign win_nb[j] = win_run[j-1];
    end
    mp2d_win_cell u_cell (
      .clk     (clk),
      .en      (adv && v2_r),
      .nb_in   (win_nb[j]),
      .x_in    (colmax2_r),
      .run_out (win_run[j]),
      .nxt_out (win_nxt[j])
    );
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pooled_max = pooled_r;
  assign out_ch.out_row    = orow_r;
  assign out_ch.out_col    = ocol_r;
  assign out_ch.plane_done = pdone_r;

  `MP2D_ASSERT_NXT(a_stall_holds_pipe, !adv, $stable(v1_r) && $stable(v2_r) && $stable(col_cnt_r), "pipeline moved during output stall")
  `MP2D_ASSERT_NXT(a_emit_loads_out, adv && emit2, out_ch.valid, "window result not presented")
  `MP2D_ASSERT_NXT(a_accept_fills, acc, v1_r && (c1_r == $past(c_pre)), "accepted sample lost")
  `MP2D_ASSERT_IMP(a_done_needs_result, out_valid_r && !out_ch.ready, in_ch.ready == 1'b0, "input taken while result blocked")

endmodule

FILE: tb/sv/max_pool_2d_forward_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// max pool 2d forward testbench
// streams raster-order sample planes through the pooling block under a
// range of window, stride and plane settings, predicts every window maximum
// with its position and end-of-plane flag, and checks each result transfer
// in order while both channels idle and stall at random
// ----------------------------------------------------------------------------
module max_pool_2d_forward_tb;
  import mp2d_pkg::*;

  localparam int          LIMIT_CYCLES  = 1000000;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          RAND_ITEMS    = 1050;
  localparam int          HOLD_CYCLES   = 300;
  localparam int unsigned KERN_CAP      = 8;
  localparam int unsigned WIDTH_CAP     = 1024;
  localparam int unsigned HEIGHT_CAP    = 1024;

  typedef struct packed {
    sample_t pooled_max;
    idx_t    out_row;
    idx_t    out_col;
    logic    plane_done;
  } window_t;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     cfg_we    = 1'b0;
  cfg_idx_t                 cfg_index = CFG_KERNEL_SIZE;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

  mp2d_in_if  in_if ();
  mp2d_out_if out_if ();

  max_pool_2d_forward dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // shadow of the pooling state
  sample_t              line_mem [KERN_CAP][WIDTH_CAP];
  logic [KCFG_BITS-1:0] kern_reg;
  logic [KCFG_BITS-1:0] step_reg;
  logic [DIM_BITS-1:0]  wid_reg;
  logic [DIM_BITS-1:0]  hgt_reg;
  int unsigned          row_pos;
  int unsigned          col_pos;

  sample_t sample_q [$];
  window_t window_q [$];
  int      errors;
  int      sent_count;
  longint  cycles;
  bit      src_idle;
  bit      sink_idle;
  bit      hold_req;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic sample_t draw_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2, 3: return sample_t'($urandom_range(0, 6)) - 16'sd3;
      4: return {1'b1, 15'($urandom)};
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic pool_step(input sample_t x);
    int unsigned k, s, w, h, r, c, r0, c0, hout, wout, lastr, lastc, i, j;
    sample_t     best;
    window_t     res;
    k = clamp_dim(kern_reg, KERN_CAP);
    s = clamp_dim(step_reg, KERN_CAP);
    w = clamp_dim(wid_reg, WIDTH_CAP);
    h = clamp_dim(hgt_reg, HEIGHT_CAP);
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    line_mem[r % k][c] = x;
    if (k <= w && k <= h && r + 1 >= k && c + 1 >= k &&
        (r + 1 - k) % s == 0 && (c + 1 - k) % s == 0) begin
      r0 = r + 1 - k;
      c0 = c + 1 - k;
      hout = (h - k) / s + 1;
      wout = (w - k) / s + 1;
      lastr = (hout - 1) * s + k - 1;
      lastc = (wout - 1) * s + k - 1;
      best = line_mem[r0 % k][c0];
      for (i = 0; i < k; i++) begin
        for (j = 0; j < k; j++) begin
          if (line_mem[(r0 + i) % k][c0 + j] > best) best = line_mem[(r0 + i) % k][c0 + j];
        end
      end
      res.pooled_max = best;
      res.out_row    = idx_t'(r0 / s);
      res.out_col    = idx_t'(c0 / s);
      res.plane_done = (r == lastr && c == lastc);
      window_q.push_back(res);
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // monitor: input transfers feed the predictor, result transfers are checked
  always @(posedge clk) begin : monitor
    window_t want;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) pool_step(in_if.sample);
      if (out_if.valid && out_if.ready) begin
        if (window_q.size() == 0) begin
          flag_error($sformatf("result with none pending: max %0d row %0d col %0d",
                               out_if.pooled_max, out_if.out_row, out_if.out_col));
        end else begin
          want = window_q.pop_front();
          if (out_if.pooled_max !== want.pooled_max)
            flag_error($sformatf("pooled_max got %0d want %0d at row %0d col %0d",
                                 out_if.pooled_max, want.pooled_max, want.out_row,
                                 want.out_col));
          if (out_if.out_row !== want.out_row)
            flag_error($sformatf("out_row got %0d want %0d", out_if.out_row, want.out_row));
          if (out_if.out_col !== want.out_col)
            flag_error($sformatf("out_col got %0d want %0d", out_if.out_col, want.out_col));
          if (out_if.plane_done !== want.plane_done)
            flag_error($sformatf("plane_done got %0b want %0b at row %0d col %0d",
                                 out_if.plane_done, want.plane_done, want.out_row,
                                 want.out_col));
        end
      end
    end
  end

  // sample driver
  always @(posedge clk) begin : driver
    int gap_left;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        void'(sample_q.pop_front());
        gap_left = src_idle ? $urandom_range(0, 10) : 0;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        in_if.valid  <= 1'b1;
        in_if.sample <= sample_q[0];
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and one long hold-off
  always @(posedge clk) begin : receiver
    int stall_left;
    int hold_left;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (out_if.valid && out_if.ready) stall_left = sink_idle ? $urandom_range(0, 10) : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("max_pool_2d_forward_tb NOT OK");
      $finish;
    end
  end

  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_KERNEL_SIZE:  kern_reg = val[KCFG_BITS-1:0];
      CFG_STRIDE_STEP:  step_reg = val[KCFG_BITS-1:0];
      CFG_PLANE_WIDTH:  wid_reg  = val[DIM_BITS-1:0];
      CFG_PLANE_HEIGHT: hgt_reg  = val[DIM_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_pooling(input int unsigned k, input int unsigned s,
                             input int unsigned w, input int unsigned h);
    cfg_write(CFG_KERNEL_SIZE, k);
    cfg_write(CFG_STRIDE_STEP, s);
    cfg_write(CFG_PLANE_WIDTH, w);
    cfg_write(CFG_PLANE_HEIGHT, h);
  endtask

  task automatic push_value(input sample_t v);
    sample_q.push_back(v);
    sent_count++;
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) push_value(draw_sample());
  endtask

  // wait until every sample is in and every window is out, block gone quiet
  task automatic drain();
    do begin
      while (sample_q.size() != 0 || window_q.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (sample_q.size() != 0 || window_q.size() != 0);
  endtask

  // complete the current plane so that the counters return to the origin
  task automatic finish_plane();
    int unsigned w, h, r, c;
    w = clamp_dim(wid_reg, WIDTH_CAP);
    h = clamp_dim(hgt_reg, HEIGHT_CAP);
    r = row_pos;
    c = col_pos;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) r = 0;
    if (r != 0 || c != 0) push_random(h * w - (r * w + c));
    drain();
  endtask

  initial begin : stimulus
    int unsigned k, s, w, h, we, he, ke, m, planes, part, pick, base;
    in_if.valid   = 1'b0;
    in_if.sample  = '0;
    out_if.ready  = 1'b0;
    errors        = 0;
    sent_count    = 0;
    cycles        = 0;
    src_idle      = 1'b1;
    sink_idle     = 1'b1;
    hold_req      = 1'b0;
    kern_reg      = KERNEL_RST;
    step_reg      = STRIDE_RST;
    wid_reg       = WIDTH_RST;
    hgt_reg       = HEIGHT_RST;
    row_pos       = 0;
    col_pos       = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // extremes of the sample range in a 2x2 window
    set_pooling(2, 2, 4, 2);
    push_value(16'sh8000);
    push_value(16'sh7fff);
    push_value(16'sh0001);
    push_value(16'shffff);
    repeat (4) push_value(16'sh8000);
    drain();

    // kernel larger than the plane, nothing comes out
    set_pooling(3, 1, 2, 2);
    push_value(16'sh7fff);
    push_random(3);
    drain();

    // single-pixel planes
    set_pooling(1, 1, 1, 1);
    push_value(16'sh7fff);
    push_value(16'sh8000);
    drain();

    // zero kernel and stride act as one
    set_pooling(0, 0, 3, 1);
    push_random(3);
    drain();

    // stride wider than the kernel skips columns
    set_pooling(1, 3, 5, 2);
    push_random(10);
    drain();

    // long receiver hold-off with a steady sender fills the block
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    set_pooling(2, 1, 16, 8);
    hold_req = 1'b1;
    push_random(128);
    drain();

    base = sent_count;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    set_pooling(8, 8, 8, 8);
    push_random(64);
    drain();
    set_pooling(15, 12, 9, 9);
    push_random(81);
    drain();
    set_pooling(8, 1, 10, 9);
    push_random(90);
    drain();

    while (sent_count - base < RAND_ITEMS) begin
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      w = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      we = clamp_dim(w, WIDTH_CAP);
      h = ($urandom_range(0, 9) == 0) ? 0 :
          (we > 12) ? $urandom_range(1, 4) : $urandom_range(1, 10);
      he = clamp_dim(h, HEIGHT_CAP);
      m = (we < he) ? we : he;
      if (m > KERN_CAP) m = KERN_CAP;
      pick = $urandom_range(0, 9);
      if (pick == 0) k = 0;
      else if (pick == 1) k = $urandom_range(9, 15);
      else if (pick == 2) k = $urandom_range(1, 8);
      else k = $urandom_range(1, m);
      ke = clamp_dim(k, KERN_CAP);
      pick = $urandom_range(0, 9);
      if (pick == 0) s = 0;
      else if (pick == 1) s = $urandom_range(9, 15);
      else if (pick == 2) s = $urandom_range(1, 8);
      else s = $urandom_range(1, ke);
      set_pooling(k, s, w, h);
      if (we * he > 1 && $urandom_range(0, 4) == 0) begin
        // plane broken by a stride or height change partway through
        part = $urandom_range(1, we * he - 1);
        push_random(part);
        drain();
        if ($urandom_range(0, 1) != 0) cfg_write(CFG_STRIDE_STEP, $urandom_range(1, 8));
        else cfg_write(CFG_PLANE_HEIGHT, he + $urandom_range(0, 4));
        finish_plane();
      end else begin
        planes = (we * he > 60) ? 1 : $urandom_range(1, 3);
        push_random(planes * we * he);
        drain();
      end
    end

    // widest and tallest planes
    src_idle  = 1'b0;
    sink_idle = 1'b1;
    set_pooling(1, 3, 1024, 1);
    push_random(1024);
    drain();
    set_pooling(1, 8, 1, 2047);
    push_random(1024);
    drain();
    set_pooling(2, 5, 2047, 2);
    push_random(2048);
    drain();
    src_idle = 1'b1;
    set_pooling(0, 0, 0, 0);
    push_random(3);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (window_q.size() != 0) flag_error($sformatf("%0d windows never came", window_q.size()));
    if (errors == 0) begin
      $display("max_pool_2d_forward_tb OK");
    end else begin
      $display("max_pool_2d_forward_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/mp2d_pkg.sv
hw/rtl/mp2d_in_if.sv
hw/rtl/mp2d_out_if.sv
hw/rtl/mp2d_line_cell.sv
hw/rtl/mp2d_win_cell.sv
hw/rtl/max_pool_2d_forward.sv
tb/sv/max_pool_2d_forward_tb.sv
